// ===== src/trn_pkg.sv =====
`timescale 1ns / 1ps

package trn_pkg;

  // Telnet command codes.
  localparam logic [7:0] Iac  = 8'd255;
  localparam logic [7:0] Dont = 8'd254;
  localparam logic [7:0] Do   = 8'd253;
  localparam logic [7:0] Wont = 8'd252;
  localparam logic [7:0] Will = 8'd251;
  localparam logic [7:0] Sb   = 8'd250;
  localparam logic [7:0] Se   = 8'd240;

  // Option codes that get special handling.
  localparam logic [7:0] OptEcho = 8'd1;
  localparam logic [7:0] OptTerm = 8'd24;

  // Terminal-type reply length and default queue depth.
  localparam int unsigned TermLen       = 11;
  localparam int unsigned DefQueueDepth = 2;

  localparam int unsigned IdxW = $clog2(TermLen);

  // Kinds of work the front end hands to the back end.
  typedef enum logic [1:0] {
    JobData,
    JobReply,
    JobTerm
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] verb;
    logic [7:0] val;
  } job_t;

  // Terminal-type subnegotiation reply: IAC SB 24 0 "vt320" IAC SE.
  function automatic logic [7:0] term_byte(input logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = Iac;
      4'd1:    b = Sb;
      4'd2:    b = OptTerm;
      4'd3:    b = 8'd0;
      4'd4:    b = 8'h76;
      4'd5:    b = 8'h74;
      4'd6:    b = 8'h33;
      4'd7:    b = 8'h32;
      4'd8:    b = 8'h30;
      4'd9:    b = Iac;
      4'd10:   b = Se;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/trn_front.sv =====
`timescale 1ns / 1ps

module trn_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    rx_byte_i,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output trn_pkg::job_t job_o
);

  localparam logic [1:0] ModeData = 2'd0;
  localparam logic [1:0] ModeCmd  = 2'd1;
  localparam logic [1:0] ModeOpt  = 2'd2;
  localparam logic [1:0] ModeSkip = 2'd3;

  logic [1:0]    mode_q, mode_d;
  logic [7:0]    cmd_q, cmd_d;
  logic          echo_q, echo_d;
  logic          accept;
  logic          job_valid;
  trn_pkg::job_t job;

  // A byte is taken whenever the queue has room for the work it might cause.
  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign push_o     = accept && job_valid;
  assign job_o      = job;

  // Parser: next state and the job, if any, for the current byte.
  always_comb begin
    mode_d    = mode_q;
    cmd_d     = cmd_q;
    echo_d    = echo_q;
    job_valid = 1'b0;
    job.kind  = trn_pkg::JobData;
    job.verb  = trn_pkg::Iac;
    job.val   = rx_byte_i;
    case (mode_q)
      ModeData: begin
        if (rx_byte_i == trn_pkg::Iac) begin
          mode_d = ModeCmd;
        end else if (echo_q) begin
          job_valid = 1'b1;
        end
      end
      ModeCmd: begin
        cmd_d = rx_byte_i;
        if (rx_byte_i inside {trn_pkg::Sb, trn_pkg::Will, trn_pkg::Wont,
                              trn_pkg::Do, trn_pkg::Dont}) begin
          mode_d = ModeOpt;
        end else begin
          mode_d = ModeData;
        end
      end
      ModeOpt: begin
        mode_d   = (cmd_q == trn_pkg::Sb) ? ModeSkip : ModeData;
        job.kind = trn_pkg::JobReply;
        if (rx_byte_i == trn_pkg::OptEcho) begin
          if (cmd_q == trn_pkg::Will) begin
            echo_d    = 1'b1;
            job_valid = 1'b1;
            job.verb  = trn_pkg::Do;
          end else if (cmd_q == trn_pkg::Wont) begin
            echo_d    = 1'b0;
            job_valid = 1'b1;
            job.verb  = trn_pkg::Dont;
          end else if (cmd_q == trn_pkg::Do || cmd_q == trn_pkg::Dont) begin
            job_valid = 1'b1;
            job.verb  = trn_pkg::Wont;
          end
        end else if (rx_byte_i == trn_pkg::OptTerm) begin
          if (cmd_q == trn_pkg::Sb) begin
            job_valid = 1'b1;
            job.kind  = trn_pkg::JobTerm;
          end else if (cmd_q == trn_pkg::Will) begin
            job_valid = 1'b1;
            job.verb  = trn_pkg::Dont;
          end else if (cmd_q == trn_pkg::Do) begin
            job_valid = 1'b1;
            job.verb  = trn_pkg::Will;
          end
        end else if (rx_byte_i inside {[8'd0:8'd37], 8'd39, 8'd255}) begin
          if (cmd_q == trn_pkg::Will) begin
            job_valid = 1'b1;
            job.verb  = trn_pkg::Dont;
          end else if (cmd_q == trn_pkg::Do) begin
            job_valid = 1'b1;
            job.verb  = trn_pkg::Wont;
          end
        end
      end
      default: begin
        if (rx_byte_i == trn_pkg::Iac) begin
          mode_d = ModeCmd;
        end
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeData;
      cmd_q  <= trn_pkg::Sb;
      echo_q <= 1'b1;
    end else if (accept) begin
      mode_q <= mode_d;
      cmd_q  <= cmd_d;
      echo_q <= echo_d;
    end
  end

endmodule

// ===== src/trn_queue.sv =====
`timescale 1ns / 1ps

module trn_queue #(
  parameter int unsigned Depth = trn_pkg::DefQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  trn_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output trn_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  trn_pkg::job_t     mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage for queued jobs.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/trn_back.sv =====
`timescale 1ns / 1ps

module trn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  trn_pkg::job_t head_i,
  output logic          pop_o,
  output logic          dest_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  localparam logic [trn_pkg::IdxW-1:0] ReplyLast = trn_pkg::IdxW'(2);
  localparam logic [trn_pkg::IdxW-1:0] TermLast  = trn_pkg::IdxW'(trn_pkg::TermLen - 1);

  logic [trn_pkg::IdxW-1:0] idx_q;
  logic                     valid_q;
  logic                     dest_q, last_q;
  logic [7:0]               byte_q;
  logic                     load;
  logic                     w_dest, w_last;
  logic [7:0]               w_byte;

  // The output register takes a new word when empty or being drained.
  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && w_last;

  // Word selection for the current job and position.
  always_comb begin
    w_dest = 1'b1;
    w_last = 1'b0;
    w_byte = head_i.val;
    case (head_i.kind)
      trn_pkg::JobData: begin
        w_dest = 1'b0;
        w_last = 1'b1;
      end
      trn_pkg::JobReply: begin
        w_last = (idx_q == ReplyLast);
        if (idx_q == '0) begin
          w_byte = trn_pkg::Iac;
        end else if (idx_q == trn_pkg::IdxW'(1)) begin
          w_byte = head_i.verb;
        end
      end
      trn_pkg::JobTerm: begin
        w_last = (idx_q == TermLast);
        w_byte = trn_pkg::term_byte(idx_q);
      end
      default: begin
        w_last = 1'b1;
      end
    endcase
  end

  // Word counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= w_last ? '0 : idx_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dest_q <= w_dest;
      byte_q <= w_byte;
      last_q <= w_last;
    end
  end

  assign dest_o      = dest_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign out_valid_o = valid_q;

endmodule

// ===== src/telnet_receive_negotiator.sv =====
`timescale 1ns / 1ps

// Receive-side telnet negotiator. Each accepted rx byte is parsed in the
// same cycle and, if it causes output, queued as one job; a back end turns
// jobs into words through a registered output, one word per cycle while
// out_ready is high; data bytes pass only while echo is on. A negotiation
// reply is three words and a terminal-type reply eleven; meanwhile the
// input keeps being taken until the job queue of QueueDepth entries is
// full. dest is 0 for terminal bytes and 1 for bytes to the peer, and last
// marks the final word caused by one input byte.
module telnet_receive_negotiator #(
  parameter int unsigned QueueDepth = trn_pkg::DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  output logic       dest_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic          push, pop, full, empty;
  trn_pkg::job_t job_in, job_head;

  // Parser.
  trn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Job queue.
  trn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (job_head)
  );

  // Word generator.
  trn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (job_head),
    .pop_o       (pop),
    .dest_o      (dest_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
